FILE: hw/rtl/uep0seq_pkg.sv
// Package for the endpoint-0 control sequencer: codes, field widths,
// state and word types, and the packet-size helper.
// No dependencies.
`timescale 1ns / 1ps

package uep0seq_pkg;

  localparam int EP0_PACKET = 64;
  localparam logic [15:0] EP0_PACKET_W = 16'(EP0_PACKET);

  // event codes (tuser)
  localparam logic [3:0] CMD_RESET    = 4'd0;
  localparam logic [3:0] CMD_SETUP    = 4'd1;
  localparam logic [3:0] CMD_IN_DONE  = 4'd2;
  localparam logic [3:0] CMD_OUT_DONE = 4'd3;
  localparam logic [3:0] CMD_DATA_IN  = 4'd4;
  localparam logic [3:0] CMD_DATA_OUT = 4'd5;
  localparam logic [3:0] CMD_ZLP      = 4'd6;
  localparam logic [3:0] CMD_STALL    = 4'd7;
  localparam logic [3:0] CMD_ADDR     = 4'd8;

  // control phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_DATA_IN    = 3'd1;
  localparam logic [2:0] PH_DATA_OUT   = 3'd2;
  localparam logic [2:0] PH_STATUS_IN  = 3'd3;
  localparam logic [2:0] PH_STATUS_OUT = 3'd4;
  localparam logic [2:0] PH_PEND_ADDR  = 3'd5;

  // dispatch classes
  localparam logic [1:0] DISP_NONE  = 2'd0;
  localparam logic [1:0] DISP_STD   = 2'd1;
  localparam logic [1:0] DISP_CLASS = 2'd2;
  localparam logic [1:0] DISP_STALL = 2'd3;

  // bmRequestType type bits
  localparam logic [7:0] RT_TYPE_MASK  = 8'h60;
  localparam logic [7:0] RT_TYPE_STD   = 8'h00;
  localparam logic [7:0] RT_TYPE_CLASS = 8'h20;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [7:0]  request_type;
    logic [15:0] data_len;
    logic [15:0] host_len;
    logic [6:0]  new_address;
  } item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] bytes_left;
    logic [15:0] next_offset;
    logic        zlp_owed;
    logic [6:0]  held_address;
    logic [6:0]  bus_address;
    logic        stalled;
  } ctrl_st_t;

  typedef struct packed {
    logic [2:0]  ctrl_state;
    logic [1:0]  dispatch;
    logic        in_fire;
    logic [6:0]  in_count;
    logic [15:0] in_offset;
    logic        out_armed;
    logic        stall_active;
    logic        addr_write;
    logic [6:0]  device_address;
  } result_t;

  localparam ctrl_st_t ST_RESET = '{default: '0};

  function automatic logic [15:0] chunk_of(input logic [15:0] left);
    return (left > EP0_PACKET_W) ? EP0_PACKET_W : left;
  endfunction

endpackage

FILE: hw/rtl/uep0seq_step.sv
// Next-state and result logic for one control event.
// Uses uep0seq_pkg.
`timescale 1ns / 1ps

module uep0seq_step (
  input  uep0seq_pkg::item_t    item,
  input  uep0seq_pkg::ctrl_st_t cur,
  output uep0seq_pkg::ctrl_st_t nxt,
  output uep0seq_pkg::result_t  res
);

  logic [15:0] len;
  logic [15:0] first_chunk;
  logic [15:0] left_chunk;
  logic [7:0]  rtype;
  logic [1:0]  disp;
  logic        fire;
  logic [6:0]  cnt;
  logic [15:0] off;
  logic        awrite;

  assign len         = (item.data_len > item.host_len) ? item.host_len : item.data_len;
  assign first_chunk = uep0seq_pkg::chunk_of(len);
  assign left_chunk  = uep0seq_pkg::chunk_of(cur.bytes_left);
  assign rtype       = item.request_type & uep0seq_pkg::RT_TYPE_MASK;

  always_comb begin
    nxt    = cur;
    disp   = uep0seq_pkg::DISP_NONE;
    fire   = 1'b0;
    cnt    = '0;
    off    = '0;
    awrite = 1'b0;
    case (item.cmd)
      uep0seq_pkg::CMD_RESET: begin
        nxt    = uep0seq_pkg::ST_RESET;
        awrite = 1'b1;
      end
      uep0seq_pkg::CMD_SETUP: begin
        nxt.stalled = 1'b0;
        if (rtype == uep0seq_pkg::RT_TYPE_STD) begin
          disp = uep0seq_pkg::DISP_STD;
        end else if (rtype == uep0seq_pkg::RT_TYPE_CLASS) begin
          disp = uep0seq_pkg::DISP_CLASS;
        end else begin
          disp        = uep0seq_pkg::DISP_STALL;
          nxt.stalled = 1'b1;
          nxt.phase   = uep0seq_pkg::PH_IDLE;
        end
      end
      uep0seq_pkg::CMD_IN_DONE: begin
        if (cur.phase == uep0seq_pkg::PH_DATA_IN) begin
          if (cur.bytes_left != '0) begin
            fire            = 1'b1;
            cnt             = left_chunk[6:0];
            off             = cur.next_offset;
            nxt.bytes_left  = cur.bytes_left - left_chunk;
            nxt.next_offset = cur.next_offset + left_chunk;
          end else if (cur.zlp_owed) begin
            // terminating zero-length packet
            nxt.zlp_owed = 1'b0;
            fire         = 1'b1;
            off          = cur.next_offset;
          end else begin
            nxt.phase = uep0seq_pkg::PH_STATUS_OUT;
          end
        end else if (cur.phase == uep0seq_pkg::PH_PEND_ADDR) begin
          nxt.bus_address  = cur.held_address;
          nxt.held_address = '0;
          awrite           = 1'b1;
          nxt.phase        = uep0seq_pkg::PH_IDLE;
        end else begin
          nxt.phase = uep0seq_pkg::PH_IDLE;
        end
      end
      uep0seq_pkg::CMD_OUT_DONE: begin
        if (cur.phase == uep0seq_pkg::PH_DATA_OUT) begin
          fire      = 1'b1;
          nxt.phase = uep0seq_pkg::PH_STATUS_IN;
        end else begin
          nxt.phase = uep0seq_pkg::PH_IDLE;
        end
      end
      uep0seq_pkg::CMD_DATA_IN: begin
        nxt.zlp_owed    = (len < item.host_len) && (len != '0) &&
                          ((len % uep0seq_pkg::EP0_PACKET_W) == '0);
        nxt.phase       = uep0seq_pkg::PH_DATA_IN;
        fire            = 1'b1;
        cnt             = first_chunk[6:0];
        nxt.bytes_left  = len - first_chunk;
        nxt.next_offset = first_chunk;
      end
      uep0seq_pkg::CMD_DATA_OUT: begin
        nxt.phase = uep0seq_pkg::PH_DATA_OUT;
      end
      uep0seq_pkg::CMD_ZLP: begin
        fire      = 1'b1;
        nxt.phase = uep0seq_pkg::PH_STATUS_IN;
      end
      uep0seq_pkg::CMD_STALL: begin
        nxt.stalled = 1'b1;
        nxt.phase   = uep0seq_pkg::PH_IDLE;
      end
      uep0seq_pkg::CMD_ADDR: begin
        nxt.held_address = item.new_address;
        fire             = 1'b1;
        nxt.phase        = uep0seq_pkg::PH_PEND_ADDR;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.ctrl_state     = nxt.phase;
    res.dispatch       = disp;
    res.in_fire        = fire;
    res.in_count       = cnt;
    res.in_offset      = off;
    res.out_armed      = (nxt.phase == uep0seq_pkg::PH_DATA_IN) ||
                         (nxt.phase == uep0seq_pkg::PH_DATA_OUT) ||
                         (nxt.phase == uep0seq_pkg::PH_STATUS_OUT);
    res.stall_active   = nxt.stalled;
    res.addr_write     = awrite;
    res.device_address = nxt.bus_address;
  end

endmodule

FILE: hw/rtl/usb_ep0_control_sequencer.sv
// Endpoint-0 control-transfer sequencer: input register, event logic,
// result register. Uses uep0seq_pkg and uep0seq_step.
`timescale 1ns / 1ps
// Each event passes through the input register, then the result register.
// Throughput: one event per cycle unless the result is stalled; the control
// state updates as a word moves from the input register to the result register.
// Reset (rst, synchronous): both stages empty, phase idle, addresses zero,
// stall cleared.

module usb_ep0_control_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] request_type, [23:8] data_len, [39:24] host_len, [46:40] new_address
  input  logic [47:0] s_axis_tdata,
  // [3:0] cmd
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] ctrl_state, [4:3] dispatch, [5] in_fire, [12:6] in_count,
  // [28:13] in_offset, [29] out_armed, [30] stall_active, [31] addr_write,
  // [38:32] device_address
  output logic [39:0] m_axis_tdata
);

  logic                  in_valid;
  uep0seq_pkg::item_t    in_item;
  uep0seq_pkg::ctrl_st_t st;
  uep0seq_pkg::ctrl_st_t st_next;
  uep0seq_pkg::result_t  res;
  logic                  out_valid;
  logic [39:0]           out_word;
  logic                  out_free;
  logic                  adv;

  assign out_free      = !out_valid || m_axis_tready;
  assign adv           = in_valid && out_free;
  assign s_axis_tready = !in_valid || adv;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;

  uep0seq_step u_step (
    .item (in_item),
    .cur  (st),
    .nxt  (st_next),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= uep0seq_pkg::ST_RESET;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
      if (adv) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.cmd          <= s_axis_tuser;
      in_item.request_type <= s_axis_tdata[7:0];
      in_item.data_len     <= s_axis_tdata[23:8];
      in_item.host_len     <= s_axis_tdata[39:24];
      in_item.new_address  <= s_axis_tdata[46:40];
    end
    if (adv) begin
      out_word <= {1'b0, res.device_address, res.addr_write, res.stall_active,
                   res.out_armed, res.in_offset, res.in_count, res.in_fire,
                   res.dispatch, res.ctrl_state};
    end
  end

endmodule

FILE: hw/rtl/uep0seq_checker.sv
// Port-level checks for the endpoint-0 sequencer, bound to the top level.
// Uses uep0seq_pkg.
`timescale 1ns / 1ps

module uep0seq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic [2:0] o_state;
  logic [1:0] o_disp;
  logic       o_fire;
  logic [6:0] o_count;
  logic [15:0] o_offset;
  logic       o_armed;
  logic       o_awrite;

  assign o_state  = m_axis_tdata[2:0];
  assign o_disp   = m_axis_tdata[4:3];
  assign o_fire   = m_axis_tdata[5];
  assign o_count  = m_axis_tdata[12:6];
  assign o_offset = m_axis_tdata[28:13];
  assign o_armed  = m_axis_tdata[29];
  assign o_awrite = m_axis_tdata[31];

  // no packet armed means no count and no offset
  a_idle_fire: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !o_fire |-> o_count == '0 && o_offset == '0)
    else $error("count or offset without an armed IN packet");

  // a setup word never fires a packet or writes the address
  a_setup_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_disp != uep0seq_pkg::DISP_NONE |-> !o_fire && !o_awrite)
    else $error("setup word with packet or address write");

  a_out_armed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> o_armed == ((o_state == uep0seq_pkg::PH_DATA_IN) ||
                                  (o_state == uep0seq_pkg::PH_DATA_OUT) ||
                                  (o_state == uep0seq_pkg::PH_STATUS_OUT)))
    else $error("out_armed disagrees with ctrl_state");

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

endmodule

bind usb_ep0_control_sequencer uep0seq_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
